// ===== hdl/cba_pkg.sv =====
// ---------------------------------------------------------------------------
// cba_pkg
// Shared types, widths and codes of the cluster bitmap allocator.
// ---------------------------------------------------------------------------
package cba_pkg;

    localparam int NUM_CLUSTERS  = 4096;
    localparam int CL_W          = $clog2(NUM_CLUSTERS);
    localparam int CNT_W         = CL_W + 1;
    localparam int WORD_W        = 64;
    localparam int BIT_W         = $clog2(WORD_W);
    localparam int ROWS          = NUM_CLUSTERS / WORD_W;
    localparam int ROW_W         = CL_W - BIT_W;
    localparam int MAX_FRAGMENTS = 32;
    localparam int FRAG_AW       = $clog2(MAX_FRAGMENTS);
    localparam int NF_W          = FRAG_AW + 1;
    localparam int FRAG_W        = CL_W + CNT_W;
    localparam int POP_W         = BIT_W + 1;

    // actions
    localparam logic [2:0] ACT_MARK_USED = 3'd0;
    localparam logic [2:0] ACT_MARK_FREE = 3'd1;
    localparam logic [2:0] ACT_FIRST_FIT = 3'd2;
    localparam logic [2:0] ACT_GATHER    = 3'd3;
    localparam logic [2:0] ACT_COUNT     = 3'd4;
    localparam logic [2:0] ACT_QUERY     = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_TOO_MANY  = 2'd3;

    typedef struct packed {
        logic [2:0]       action;
        logic [CL_W-1:0]  first_cluster;
        logic [CNT_W-1:0] run_length;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [CL_W-1:0]  frag_start;
        logic [CNT_W-1:0] frag_length;
        logic             cluster_used;
        logic [CNT_W-1:0] free_total;
        logic             last;
    } t_out;

endpackage

// ===== hdl/cba_ram.sv =====
// ---------------------------------------------------------------------------
// cba_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module cba_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on collision
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/cluster_bitmap_allocator.sv =====
// Mark and count work one 64-cluster row per pass; query reads a single row; range errors,
// empty runs and misses at the start go straight to the result; first fit scans bit-serially,
// cluster by cluster, reading each row as it is entered; gather scans alike, then emits its
// fragment words one by one. One item at a time, the next accepted the cycle after the
// last word is loaded; set by the single bitmap RAM port and the bit-serial scan.
// Reset: synchronous active low; all clusters free through per-row valid bits.
// ---------------------------------------------------------------------------
// cluster_bitmap_allocator
// Used/free cluster bitmap with mark, query, count, first-fit and gather.
// ---------------------------------------------------------------------------
module cluster_bitmap_allocator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  cba_pkg::t_in             i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output cba_pkg::t_out            o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [cba_pkg::CNT_W-1:0] i_cfg_data
);
    import cba_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MK_RD   = 4'd1;
    localparam logic [3:0] S_MK_WR   = 4'd2;
    localparam logic [3:0] S_CNT_RD  = 4'd3;
    localparam logic [3:0] S_CNT_ACC = 4'd4;
    localparam logic [3:0] S_QRY_RD  = 4'd5;
    localparam logic [3:0] S_QRY_BIT = 4'd6;
    localparam logic [3:0] S_SR_RD   = 4'd7;
    localparam logic [3:0] S_SR_BIT  = 4'd8;
    localparam logic [3:0] S_EMIT_RD = 4'd9;
    localparam logic [3:0] S_EMIT_LD = 4'd10;
    localparam logic [3:0] S_RESP    = 4'd11;

    localparam logic [WORD_W-1:0] ONES = '1;

    logic [3:0]       r_state;
    logic [CNT_W-1:0] r_cfg;
    logic [2:0]       r_act;
    logic [CL_W-1:0]  r_first;
    logic [CL_W-1:0]  r_end;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_cnt;
    logic [ROW_W-1:0] r_w;
    logic [CNT_W-1:0] r_idx;
    logic [CL_W-1:0]  r_run_start;
    logic [CNT_W-1:0] r_run_len;
    logic [CNT_W-1:0] r_got;
    logic [NF_W-1:0]  r_nf;
    logic [FRAG_AW-1:0] r_k;
    logic [CNT_W-1:0] r_acc;
    logic [ROWS-1:0]  r_row_valid;
    logic             r_bm_vld;
    t_out             r_res;
    t_out             r_out;
    logic             r_out_valid;

    logic [CNT_W-1:0] active;
    logic [CL_W+1:0]  in_sum;
    logic             out_free;
    logic [WORD_W-1:0] bm_q;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] mk_mask;
    logic [WORD_W-1:0] mk_data;
    logic [BIT_W-1:0]  mk_lo;
    logic [BIT_W-1:0]  mk_hi;
    logic              bm_we;
    logic [CNT_W-1:0]  cnt_rem;
    logic [WORD_W-1:0] cnt_bits;
    logic [POP_W-1:0]  pop;
    logic              sr_bit;
    logic [CNT_W-1:0]  nidx;
    logic [CNT_W-1:0]  nlen;
    logic [CNT_W-1:0]  ngot;
    logic [CL_W-1:0]   cur_start;
    logic              fr_we;
    logic [FRAG_W-1:0] fr_wdata;
    logic [FRAG_W-1:0] fr_q;

    // active cluster count, clamped to the bitmap size
    assign active = (r_cfg > CNT_W'(NUM_CLUSTERS)) ? CNT_W'(NUM_CLUSTERS) : r_cfg;
    assign in_sum = {2'b00, i_in_data.first_cluster} + {1'b0, i_in_data.run_length};

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // bitmap row memory, rows never written read as free
    cba_ram #(.DEPTH(ROWS), .WIDTH(WORD_W)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (r_w),
        .i_wdata (mk_data),
        .i_raddr (r_w),
        .o_rdata (bm_q)
    );
    assign word = r_bm_vld ? bm_q : '0;

    // fragment list memory
    cba_ram #(.DEPTH(MAX_FRAGMENTS), .WIDTH(FRAG_W)) u_frags (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (r_nf[FRAG_AW-1:0]),
        .i_wdata (fr_wdata),
        .i_raddr (r_k),
        .o_rdata (fr_q)
    );

    // mark mask for the current row
    always_comb begin
        mk_lo   = (r_w == r_first[CL_W-1:BIT_W]) ? r_first[BIT_W-1:0] : '0;
        mk_hi   = (r_w == r_end[CL_W-1:BIT_W]) ? r_end[BIT_W-1:0] : '1;
        mk_mask = (ONES << mk_lo) & (ONES >> (BIT_W'(WORD_W - 1) - mk_hi));
        mk_data = (r_act == ACT_MARK_USED) ? (word | mk_mask) : (word & ~mk_mask);
        bm_we   = (r_state == S_MK_WR);
    end

    // free clusters of the current row below the bound
    always_comb begin
        cnt_rem  = r_cnt - {1'b0, r_w, {BIT_W{1'b0}}};
        cnt_bits = ~word;
        if (cnt_rem < CNT_W'(WORD_W)) begin
            cnt_bits = ~word & ~(ONES << cnt_rem[BIT_W-1:0]);
        end
        pop = '0;
        for (int p = 0; p < WORD_W; p++) begin
            pop = pop + POP_W'(cnt_bits[p]);
        end
    end

    // scan step
    always_comb begin
        sr_bit    = word[r_idx[BIT_W-1:0]];
        nidx      = r_idx + 1'b1;
        nlen      = r_run_len + 1'b1;
        ngot      = r_got + 1'b1;
        cur_start = (r_run_len == '0) ? r_idx[CL_W-1:0] : r_run_start;
        fr_we     = 1'b0;
        fr_wdata  = {r_run_start, r_run_len};
        if (r_state == S_SR_BIT && r_act == ACT_GATHER) begin
            if (!sr_bit) begin
                if (ngot == r_len && !(r_run_len == '0 && r_nf == NF_W'(MAX_FRAGMENTS))) begin
                    fr_we    = 1'b1;
                    fr_wdata = {cur_start, nlen};
                end
            end else if (r_run_len != '0) begin
                fr_we = 1'b1;
            end
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CNT_W'(NUM_CLUSTERS);
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
            r_bm_vld    <= 1'b0;
        end else begin
            r_bm_vld <= r_row_valid[r_w];
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (out_free) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act       <= i_in_data.action;
                        r_first     <= i_in_data.first_cluster;
                        r_len       <= i_in_data.run_length;
                        r_cnt       <= active;
                        r_end       <= CL_W'(in_sum - 1'b1);
                        r_w         <= i_in_data.first_cluster[CL_W-1:BIT_W];
                        r_idx       <= {1'b0, i_in_data.first_cluster};
                        r_run_len   <= '0;
                        r_got       <= '0;
                        r_nf        <= '0;
                        r_acc       <= '0;
                        r_res       <= '0;
                        r_res.last  <= 1'b1;
                        case (i_in_data.action)
                            ACT_MARK_USED, ACT_MARK_FREE: begin
                                if (in_sum > {1'b0, active}) begin
                                    r_res.status <= ST_RANGE;
                                    r_state      <= S_RESP;
                                end else if (i_in_data.run_length == '0) begin
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_MK_RD;
                                end
                            end
                            ACT_FIRST_FIT, ACT_GATHER: begin
                                if (i_in_data.run_length == '0
                                    || {1'b0, i_in_data.first_cluster} >= active) begin
                                    r_res.status <= ST_NOT_FOUND;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_state <= S_SR_RD;
                                end
                            end
                            ACT_COUNT: begin
                                r_w <= '0;
                                if (active == '0) begin
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_CNT_RD;
                                end
                            end
                            ACT_QUERY: begin
                                if ({1'b0, i_in_data.first_cluster} >= active) begin
                                    r_res.status <= ST_RANGE;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_state <= S_QRY_RD;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                // read-modify-write one row per pass
                S_MK_RD: begin
                    r_state <= S_MK_WR;
                end
                S_MK_WR: begin
                    r_row_valid[r_w] <= 1'b1;
                    if (r_w == r_end[CL_W-1:BIT_W]) begin
                        r_state <= S_RESP;
                    end else begin
                        r_w     <= r_w + 1'b1;
                        r_state <= S_MK_RD;
                    end
                end
                // free count, one row per pass
                S_CNT_RD: begin
                    r_state <= S_CNT_ACC;
                end
                S_CNT_ACC: begin
                    r_acc <= r_acc + CNT_W'(pop);
                    if (cnt_rem <= CNT_W'(WORD_W)) begin
                        r_res.free_total <= r_acc + CNT_W'(pop);
                        r_state          <= S_RESP;
                    end else begin
                        r_w     <= r_w + 1'b1;
                        r_state <= S_CNT_RD;
                    end
                end
                S_QRY_RD: begin
                    r_state <= S_QRY_BIT;
                end
                S_QRY_BIT: begin
                    r_res.cluster_used <= word[r_first[BIT_W-1:0]];
                    r_state            <= S_RESP;
                end
                // bit-serial scan of the loaded row
                S_SR_RD: begin
                    r_state <= S_SR_BIT;
                end
                S_SR_BIT: begin
                    r_idx <= nidx;
                    if (!sr_bit) begin
                        r_run_start <= cur_start;
                        r_run_len   <= nlen;
                        r_got       <= ngot;
                    end else begin
                        r_run_len <= '0;
                        if (r_run_len != '0 && r_act == ACT_GATHER) begin
                            r_nf <= r_nf + 1'b1;
                        end
                    end
                    if (!sr_bit && r_act == ACT_FIRST_FIT && nlen == r_len) begin
                        r_res.frag_start  <= cur_start;
                        r_res.frag_length <= r_len;
                        r_state           <= S_RESP;
                    end else if (!sr_bit && r_act == ACT_GATHER && r_run_len == '0
                                 && r_nf == NF_W'(MAX_FRAGMENTS)) begin
                        r_res.status <= ST_TOO_MANY;
                        r_state      <= S_RESP;
                    end else if (!sr_bit && r_act == ACT_GATHER && ngot == r_len) begin
                        r_nf    <= r_nf + 1'b1;
                        r_k     <= '0;
                        r_state <= S_EMIT_RD;
                    end else if (nidx == r_cnt) begin
                        r_res.status <= ST_NOT_FOUND;
                        r_state      <= S_RESP;
                    end else if (nidx[BIT_W-1:0] == '0) begin
                        r_w     <= nidx[CL_W-1:BIT_W];
                        r_state <= S_SR_RD;
                    end
                end
                // fragment words out of the list
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out             <= '0;
                        r_out.frag_start  <= fr_q[FRAG_W-1:CNT_W];
                        r_out.frag_length <= fr_q[CNT_W-1:0];
                        r_out.last        <= ({1'b0, r_k} + 1'b1 == r_nf);
                        if ({1'b0, r_k} + 1'b1 == r_nf) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // a word without last only comes from a gather still emitting
    a_midlist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> (r_state == S_EMIT_RD || r_state == S_EMIT_LD))
        else $error("non-last word outside fragment emission");

    // fragment list never overflows
    a_nf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nf <= NF_W'(MAX_FRAGMENTS))
        else $error("fragment count beyond list depth");

    // a fragment word written only while the list has room
    a_frwr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fr_we |-> r_nf < NF_W'(MAX_FRAGMENTS))
        else $error("fragment write with full list");
`endif

endmodule

// ===== tb/sv/tb_cluster_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cluster_bitmap_allocator
// Drives mark, query, count, first-fit, gather and undefined action words into the
// cluster bitmap allocator and checks every result word against an in-bench bitmap
// predictor or a typed directed expectation. A short directed table comes first,
// then random phases under varying cluster counts and varying idling on both sides.
// ---------------------------------------------------------------------------
module tb_cluster_bitmap_allocator;
    import cba_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 9000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;

    cluster_bitmap_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    bit               used_map [NUM_CLUSTERS];
    logic [CNT_W-1:0] cluster_limit;
    t_out             expected_words[$];
    int               mismatch_count;
    int               unexpected_count;
    int               idle_in_pct;
    int               idle_out_pct;
    int               quiet_cycles;

    // directed rows: typed expectation used where has_typed is set
    typedef struct {
        t_in  word;
        bit   has_typed;
        t_out typed;
    } t_row;

    function automatic t_out make_out(logic [1:0] st, int fs, int fl, logic cu,
                                      int ft, logic lst);
        t_out o;
        o.status       = st;
        o.frag_start   = CL_W'(fs);
        o.frag_length  = CNT_W'(fl);
        o.cluster_used = cu;
        o.free_total   = CNT_W'(ft);
        o.last         = lst;
        return o;
    endfunction

    function automatic int active_clusters();
        return (cluster_limit > NUM_CLUSTERS) ? NUM_CLUSTERS : int'(cluster_limit);
    endfunction

    function automatic int free_span(int start, int limit, int bound);
        int n;
        n = 0;
        while (start + n < bound && n < limit && !used_map[start + n]) n++;
        return n;
    endfunction

    // compute results of one input word and update the bitmap
    task automatic predict_allocator(input t_in w, output t_out res[$]);
        int cnt, first, len, pos, span, got, nf, f;
        int fs_q[$];
        int fl_q[$];
        cnt   = active_clusters();
        first = int'(w.first_cluster);
        len   = int'(w.run_length);
        res   = {};
        case (w.action)
            ACT_MARK_USED, ACT_MARK_FREE: begin
                if (first + len > cnt) begin
                    res.push_back(make_out(ST_RANGE, 0, 0, 0, 0, 1));
                end else begin
                    for (int k = 0; k < len; k++)
                        used_map[first + k] = (w.action == ACT_MARK_USED);
                    res.push_back(make_out(ST_OK, 0, 0, 0, 0, 1));
                end
            end
            ACT_FIRST_FIT: begin
                pos = first;
                if (len != 0) begin
                    while (pos < cnt) begin
                        span = free_span(pos, len, cnt);
                        if (span == len) begin
                            res.push_back(make_out(ST_OK, pos, len, 0, 0, 1));
                            break;
                        end
                        pos += span + 1;
                    end
                end
                if (res.size() == 0) res.push_back(make_out(ST_NOT_FOUND, 0, 0, 0, 0, 1));
            end
            ACT_GATHER: begin
                got = 0;
                nf  = 0;
                pos = first;
                if (len != 0) begin
                    while (pos < cnt) begin
                        span = free_span(pos, len - got, cnt);
                        if (span != 0) begin
                            if (nf >= MAX_FRAGMENTS) begin
                                res.push_back(make_out(ST_TOO_MANY, 0, 0, 0, 0, 1));
                                break;
                            end
                            fs_q.push_back(pos);
                            fl_q.push_back(span);
                            nf++;
                            got += span;
                            if (got == len) begin
                                for (int k = 0; k < nf; k++)
                                    res.push_back(make_out(ST_OK, fs_q[k], fl_q[k], 0, 0,
                                                           k + 1 == nf));
                                break;
                            end
                        end
                        pos += span + 1;
                    end
                end
                if (res.size() == 0) res.push_back(make_out(ST_NOT_FOUND, 0, 0, 0, 0, 1));
            end
            ACT_COUNT: begin
                f = 0;
                for (int k = 0; k < cnt; k++) if (!used_map[k]) f++;
                res.push_back(make_out(ST_OK, 0, 0, 0, f, 1));
            end
            ACT_QUERY: begin
                if (first >= cnt) res.push_back(make_out(ST_RANGE, 0, 0, 0, 0, 1));
                else res.push_back(make_out(ST_OK, 0, 0, used_map[first], 0, 1));
            end
            default: ;
        endcase
    endtask

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // result checking at the rising edge
    always @(posedge i_clk) begin
        t_out exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected result word %p", o_out_data);
            end else begin
                exp_w = expected_words.pop_front();
                if (o_out_data !== exp_w) begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display("mismatch: expected %p actual %p", exp_w, o_out_data);
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= idle_out_pct);
    end

    // send one input word and queue its expected results; valid drops only on idle
    task automatic send_word(input t_in w, input bit has_typed, input t_out typed);
        t_out res[$];
        while ($urandom_range(99) < idle_in_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_data  <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_allocator(w, res);
        if (has_typed) res = '{typed};
        foreach (res[k]) expected_words.push_back(res[k]);
        @(negedge i_clk);
    endtask

    // write the cluster count once the block is idle
    task automatic write_cluster_limit(input logic [CNT_W-1:0] value);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cluster_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in make_in(logic [2:0] a, int fc, int rl);
        t_in w;
        w.action        = a;
        w.first_cluster = CL_W'(fc);
        w.run_length    = CNT_W'(rl);
        return w;
    endfunction

    // random word; mostly small runs, sometimes the full range
    function automatic t_in random_word();
        t_in w;
        int cnt;
        cnt = active_clusters();
        w.action = $urandom_range(99) < 3 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        if ($urandom_range(9) == 0) begin
            w.first_cluster = CL_W'($urandom);
            w.run_length    = CNT_W'($urandom_range(8191));
        end else begin
            w.first_cluster = (cnt > 0) ? CL_W'($urandom_range(cnt - 1)) : '0;
            w.run_length    = ($urandom_range(9) < 8) ? CNT_W'($urandom_range(24))
                                                      : CNT_W'($urandom_range(300));
        end
        return w;
    endfunction

    initial begin
        t_row rows[$];
        t_out none;
        int phase_items;
        none             = '0;
        mismatch_count   = 0;
        unexpected_count = 0;
        quiet_cycles     = 0;
        idle_in_pct      = 29;
        idle_out_pct     = 79;
        cluster_limit    = 13'd4096;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        foreach (used_map[k]) used_map[k] = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        rows = '{
            '{make_in(ACT_COUNT, 0, 0), 1, make_out(ST_OK, 0, 0, 0, 4096, 1)},
            '{make_in(ACT_QUERY, 4095, 0), 1, make_out(ST_OK, 0, 0, 0, 0, 1)},
            '{make_in(ACT_FIRST_FIT, 0, 0), 1, make_out(ST_NOT_FOUND, 0, 0, 0, 0, 1)},
            '{make_in(ACT_GATHER, 0, 0), 1, make_out(ST_NOT_FOUND, 0, 0, 0, 0, 1)},
            '{make_in(ACT_FIRST_FIT, 0, 4096), 1, make_out(ST_OK, 0, 4096, 0, 0, 1)},
            '{make_in(ACT_MARK_USED, 4095, 2), 1, make_out(ST_RANGE, 0, 0, 0, 0, 1)},
            '{make_in(ACT_MARK_USED, 0, 8191), 1, make_out(ST_RANGE, 0, 0, 0, 0, 1)},
            '{make_in(ACT_MARK_USED, 4095, 1), 1, make_out(ST_OK, 0, 0, 0, 0, 1)},
            '{make_in(ACT_MARK_USED, 100, 0), 1, make_out(ST_OK, 0, 0, 0, 0, 1)},
            '{make_in(ACT_QUERY, 4095, 0), 1, make_out(ST_OK, 0, 0, 1, 0, 1)},
            '{make_in(3'd6, 0, 5), 0, none},
            '{make_in(3'd7, 4095, 8191), 0, none},
            '{make_in(ACT_MARK_USED, 0, 4096), 0, none},
            '{make_in(ACT_FIRST_FIT, 0, 1), 0, none},
            '{make_in(ACT_MARK_FREE, 1, 1), 0, none},
            '{make_in(ACT_MARK_FREE, 3, 2), 0, none},
            '{make_in(ACT_MARK_FREE, 7, 3), 0, none},
            '{make_in(ACT_GATHER, 0, 6), 0, none},
            '{make_in(ACT_FIRST_FIT, 2, 3), 0, none},
            '{make_in(ACT_COUNT, 0, 0), 0, none},
            '{make_in(ACT_MARK_FREE, 0, 4096), 0, none}
        };
        foreach (rows[k]) send_word(rows[k].word, rows[k].has_typed, rows[k].typed);

        // fragment overflow: 40 odd clusters used; gathers past and at the limit
        for (int k = 0; k < 40; k++) send_word(make_in(ACT_MARK_USED, 2 * k + 1, 1), 0, none);
        send_word(make_in(ACT_GATHER, 0, 33), 0, none);
        send_word(make_in(ACT_GATHER, 0, 32), 0, none);
        send_word(make_in(ACT_MARK_FREE, 0, 4096), 0, none);

        // random phases across cluster counts and idling
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_cluster_limit(13'd0);
                1: write_cluster_limit(13'd1);
                2: write_cluster_limit(13'($urandom_range(8, 300)));
                3: write_cluster_limit(13'd8191);
                4: write_cluster_limit(13'($urandom_range(300, 4095)));
                default: write_cluster_limit(13'd4096);
            endcase
            if (p == 2) begin
                idle_in_pct  = 79;
                idle_out_pct = 29;
            end else if (p == 4) begin
                idle_in_pct  = 0;
                idle_out_pct = 0;
            end
            phase_items = (p < 2) ? 20 : 90;
            for (int k = 0; k < phase_items; k++) send_word(random_word(), 0, none);
        end

        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && unexpected_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cba_pkg.sv
hdl/cba_ram.sv
hdl/cluster_bitmap_allocator.sv
tb/sv/tb_cluster_bitmap_allocator.sv
